>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked on clk_i; checking is suspended while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SFE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define SFE_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define SFE_ASSERT(lbl, prop)
`define SFE_ASSERT_NEVER(lbl, expr)
`endif
`endif

>>> rtl/sfe_pkg.sv
// ---------------------------------------------------------------------------
// SBUS frame encoder package
// Constants, types and the microcode table of the frame sequencer.
// ---------------------------------------------------------------------------
package sfe_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CH_W         = 11;
  localparam int CH_IDX_W     = 4;
  localparam int FRAME_BYTES  = 25;
  localparam int PACKED_BYTES = 22;

  localparam logic [7:0]        SBUS_HEADER = 8'h0F;
  localparam logic [7:0]        SBUS_END    = 8'h00;
  localparam logic [CH_W-1:0]   RESET_LOW   = 11'd172;
  localparam logic [CH_W-1:0]   RESET_HIGH  = 11'd1811;
  localparam logic signed [7:0] POS_LIMIT   = 8'sd100;

  // x / 200 == (x >> 3) / 25; (y * DIV_RECIP) >> DIV_SHIFT is exact for y < 2^16
  localparam logic [19:0] DIV_RECIP = 20'd671089;
  localparam int          DIV_SHIFT = 24;

  typedef enum logic [1:0] {
    OP_SET_POS   = 2'd0,
    OP_SET_RANGE = 2'd1,
    OP_FRAME     = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    UPC_IDLE    = 4'd0,
    UPC_SC_PREP = 4'd1,
    UPC_SC_MUL  = 4'd2,
    UPC_SC_DIV  = 4'd3,
    UPC_SC_WR   = 4'd4,
    UPC_RNG_WR  = 4'd5,
    UPC_HDR     = 4'd6,
    UPC_PACK    = 4'd7,
    UPC_FLAGS   = 4'd8,
    UPC_END     = 4'd9
  } upc_e;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_SC_PREP,
    UOP_SC_MUL,
    UOP_SC_DIV,
    UOP_SC_WR,
    UOP_RNG_WR,
    UOP_EMIT
  } uop_e;

  typedef enum logic [1:0] {
    SRC_HEADER,
    SRC_PACK,
    SRC_FLAGS,
    SRC_END
  } src_e;

  typedef enum logic [1:0] {
    JMP_GOTO,
    JMP_DISPATCH,
    JMP_LOOP
  } jmp_e;

  typedef struct packed {
    uop_e uop;
    src_e src;
    logic last;
    jmp_e jmp;
    upc_e target;
  } ucode_t;

  typedef struct packed {
    logic prep;
    logic mul;
    logic div;
  } scale_ctl_t;

  function automatic ucode_t ucode_word(uop_e uop, src_e src, logic last, jmp_e jmp,
                                        upc_e target);
    ucode_t w;
    w.uop    = uop;
    w.src    = src;
    w.last   = last;
    w.jmp    = jmp;
    w.target = target;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(upc_e upc);
    ucode_t w;
    unique case (upc)
      UPC_IDLE:    w = ucode_word(UOP_NOP,     SRC_END,    1'b0, JMP_DISPATCH, UPC_IDLE);
      UPC_SC_PREP: w = ucode_word(UOP_SC_PREP, SRC_END,    1'b0, JMP_GOTO,     UPC_SC_MUL);
      UPC_SC_MUL:  w = ucode_word(UOP_SC_MUL,  SRC_END,    1'b0, JMP_GOTO,     UPC_SC_DIV);
      UPC_SC_DIV:  w = ucode_word(UOP_SC_DIV,  SRC_END,    1'b0, JMP_GOTO,     UPC_SC_WR);
      UPC_SC_WR:   w = ucode_word(UOP_SC_WR,   SRC_END,    1'b0, JMP_GOTO,     UPC_IDLE);
      UPC_RNG_WR:  w = ucode_word(UOP_RNG_WR,  SRC_END,    1'b0, JMP_GOTO,     UPC_IDLE);
      UPC_HDR:     w = ucode_word(UOP_EMIT,    SRC_HEADER, 1'b0, JMP_GOTO,     UPC_PACK);
      UPC_PACK:    w = ucode_word(UOP_EMIT,    SRC_PACK,   1'b0, JMP_LOOP,     UPC_FLAGS);
      UPC_FLAGS:   w = ucode_word(UOP_EMIT,    SRC_FLAGS,  1'b0, JMP_GOTO,     UPC_END);
      UPC_END:     w = ucode_word(UOP_EMIT,    SRC_END,    1'b1, JMP_GOTO,     UPC_IDLE);
      default:     w = ucode_word(UOP_NOP,     SRC_END,    1'b0, JMP_GOTO,     UPC_IDLE);
    endcase
    return w;
  endfunction

endpackage

>>> rtl/sfe_scale.sv
// ---------------------------------------------------------------------------
// Position scaler
// Three-stage datapath: saturate and span, multiply, divide by 200.
// ---------------------------------------------------------------------------
module sfe_scale (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sfe_pkg::scale_ctl_t            ctl_i,
  input  logic signed [7:0]              position_i,
  input  logic [sfe_pkg::CH_W-1:0]       low_i,
  input  logic [sfe_pkg::CH_W-1:0]       high_i,
  output logic [sfe_pkg::CH_W-1:0]       value_o
);

  logic signed [7:0]          pos_sat;
  logic [7:0]                 span_d, span_q;
  logic signed [11:0]         diff_d, diff_q;
  logic [sfe_pkg::CH_W-1:0]   low_q;
  logic signed [20:0]         prod;
  logic [18:0]                mag_d, mag_q;
  logic                       neg_d, neg_q;
  logic [35:0]                recip_prod;
  logic [sfe_pkg::CH_W-1:0]   quo_d, quo_q;

  always_comb begin
    if (position_i > sfe_pkg::POS_LIMIT) begin
      pos_sat = sfe_pkg::POS_LIMIT;
    end else if (position_i < -sfe_pkg::POS_LIMIT) begin
      pos_sat = -sfe_pkg::POS_LIMIT;
    end else begin
      pos_sat = position_i;
    end
    span_d = 8'(pos_sat + sfe_pkg::POS_LIMIT);
    diff_d = $signed({1'b0, high_i}) - $signed({1'b0, low_i});
  end

  always_comb begin
    prod  = $signed({1'b0, span_q}) * diff_q;
    neg_d = prod[20];
    mag_d = neg_d ? 19'(-prod) : 19'(prod);
  end

  always_comb begin
    recip_prod = 36'(mag_q[18:3]) * 36'(sfe_pkg::DIV_RECIP);
    quo_d      = recip_prod[sfe_pkg::DIV_SHIFT +: sfe_pkg::CH_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= '0;
      diff_q <= '0;
      low_q  <= '0;
      mag_q  <= '0;
      neg_q  <= 1'b0;
      quo_q  <= '0;
    end else begin
      if (ctl_i.prep) begin
        span_q <= span_d;
        diff_q <= diff_d;
        low_q  <= low_i;
      end
      if (ctl_i.mul) begin
        mag_q <= mag_d;
        neg_q <= neg_d;
      end
      if (ctl_i.div) begin
        quo_q <= quo_d;
      end
    end
  end

  assign value_o = neg_q ? (low_q - quo_q) : (low_q + quo_q);

endmodule

>>> rtl/sbus_frame_encoder_with_scaling_unit.sv
// ---------------------------------------------------------------------------
// SBUS frame encoder with scaling
// Sixteen scaled channels packed into 25-byte SBUS frames, microcoded.
// ---------------------------------------------------------------------------
// Input channel: in_valid_i/in_ready_o carry one command per transfer: op 0
// scales a stick position into a channel value, op 1 loads a channel's
// range, op 2 emits a frame, op 3 is dropped. in_ready_o is high only while
// the microcode sequencer sits at its idle step.
// Output channel: out_valid_o/out_ready_i carry one frame byte per transfer,
// last_byte_o marks byte 25. The output register lets the sequencer load the
// next byte in the cycle the current one is taken, so a frame streams at one
// byte per cycle while out_ready_i is high. A frame command moves the
// sequencer to its header step, which loads the first byte. Op 0 runs four
// microcode steps through the shared multiplier datapath, op 1 the range
// write step, op 2 the emit steps; a stall holds the byte and freezes the step.
// Reset: channel values clear to 0, ranges return to 172..1811, the flags
// register clears and the sequencer returns to idle.
// cfg_we_i writes the 4-bit flags register; write it while idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sbus_frame_encoder_with_scaling_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          op_i,
  input  logic [sfe_pkg::CH_IDX_W-1:0]        channel_i,
  input  logic signed [7:0]                   position_i,
  input  logic [sfe_pkg::CH_W-1:0]            range_min_i,
  input  logic [sfe_pkg::CH_W-1:0]            range_max_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [7:0]                          frame_byte_o,
  output logic                                last_byte_o,
  input  logic                                cfg_we_i,
  input  logic [3:0]                          cfg_wdata_i
);

  sfe_pkg::upc_e              upc_d, upc_q;
  sfe_pkg::ucode_t            cw;
  sfe_pkg::scale_ctl_t        scale_ctl;
  logic                       stall;
  logic                       emit_fire;
  logic                       in_fire;

  logic [sfe_pkg::CH_IDX_W-1:0] ch_q;
  logic signed [7:0]          pos_q;
  logic [sfe_pkg::CH_W-1:0]   rmin_q, rmax_q;
  logic [3:0]                 flags_q;

  logic [sfe_pkg::CH_W-1:0]   chan_val_q [sfe_pkg::NUM_CHANNELS];
  logic [sfe_pkg::CH_W-1:0]   chan_lo_q  [sfe_pkg::NUM_CHANNELS];
  logic [sfe_pkg::CH_W-1:0]   chan_hi_q  [sfe_pkg::NUM_CHANNELS];
  logic [sfe_pkg::CH_W-1:0]   scaled;

  logic [17:0]                pk_buf_d, pk_buf_q;
  logic [4:0]                 pk_cnt_d, pk_cnt_q;
  logic [sfe_pkg::CH_IDX_W-1:0] pk_ptr_d, pk_ptr_q;
  logic [4:0]                 pk_loop_d, pk_loop_q;
  logic [17:0]                pk_merged;
  logic [4:0]                 pk_cnt_m;
  logic                       pk_need;
  logic                       pk_done;

  logic [7:0]                 byte_d;
  logic                       out_valid_d, out_valid_q;
  logic [7:0]                 out_byte_q;
  logic                       out_last_q;

  assign cw         = sfe_pkg::ucode_rom(upc_q);
  assign in_ready_o = (cw.jmp == sfe_pkg::JMP_DISPATCH);
  assign in_fire    = in_valid_i && in_ready_o;
  assign stall      = (cw.uop == sfe_pkg::UOP_EMIT) && out_valid_q && !out_ready_i;
  assign emit_fire  = (cw.uop == sfe_pkg::UOP_EMIT) && !stall;
  assign pk_done    = (pk_loop_q == 5'(sfe_pkg::PACKED_BYTES - 1));

  // next step
  always_comb begin
    upc_d = upc_q;
    unique case (cw.jmp)
      sfe_pkg::JMP_DISPATCH: begin
        if (in_valid_i) begin
          unique case (sfe_pkg::op_e'(op_i))
            sfe_pkg::OP_SET_POS:   upc_d = sfe_pkg::UPC_SC_PREP;
            sfe_pkg::OP_SET_RANGE: upc_d = sfe_pkg::UPC_RNG_WR;
            sfe_pkg::OP_FRAME:     upc_d = sfe_pkg::UPC_HDR;
            sfe_pkg::OP_NONE:      upc_d = sfe_pkg::UPC_IDLE;
            default:               upc_d = sfe_pkg::UPC_IDLE;
          endcase
        end
      end
      sfe_pkg::JMP_GOTO: begin
        if (!stall) begin
          upc_d = cw.target;
        end
      end
      sfe_pkg::JMP_LOOP: begin
        if (!stall && pk_done) begin
          upc_d = cw.target;
        end
      end
      default: upc_d = sfe_pkg::UPC_IDLE;
    endcase
  end

  // step decode
  always_comb begin
    scale_ctl.prep = (cw.uop == sfe_pkg::UOP_SC_PREP);
    scale_ctl.mul  = (cw.uop == sfe_pkg::UOP_SC_MUL);
    scale_ctl.div  = (cw.uop == sfe_pkg::UOP_SC_DIV);
  end

  sfe_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scale_ctl),
    .position_i (pos_q),
    .low_i      (chan_lo_q[ch_q]),
    .high_i     (chan_hi_q[ch_q]),
    .value_o    (scaled)
  );

  // bit packer: top up with the next channel when fewer than eight bits wait
  always_comb begin
    pk_need   = (pk_cnt_q < 5'd8);
    pk_merged = pk_need ? (pk_buf_q | (18'(chan_val_q[pk_ptr_q]) << pk_cnt_q)) : pk_buf_q;
    pk_cnt_m  = pk_need ? (pk_cnt_q + 5'd11) : pk_cnt_q;
    pk_buf_d  = pk_buf_q;
    pk_cnt_d  = pk_cnt_q;
    pk_ptr_d  = pk_ptr_q;
    pk_loop_d = pk_loop_q;
    if (emit_fire && (cw.src == sfe_pkg::SRC_HEADER)) begin
      pk_buf_d  = '0;
      pk_cnt_d  = '0;
      pk_ptr_d  = '0;
      pk_loop_d = '0;
    end else if (emit_fire && (cw.src == sfe_pkg::SRC_PACK)) begin
      pk_buf_d  = pk_merged >> 8;
      pk_cnt_d  = pk_cnt_m - 5'd8;
      pk_ptr_d  = pk_need ? (pk_ptr_q + 4'd1) : pk_ptr_q;
      pk_loop_d = pk_done ? 5'd0 : (pk_loop_q + 5'd1);
    end
  end

  always_comb begin
    case (cw.src)
      sfe_pkg::SRC_HEADER: byte_d = sfe_pkg::SBUS_HEADER;
      sfe_pkg::SRC_PACK:   byte_d = pk_merged[7:0];
      sfe_pkg::SRC_FLAGS:  byte_d = {4'b0000, flags_q};
      default:             byte_d = sfe_pkg::SBUS_END;
    endcase
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= sfe_pkg::UPC_IDLE;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      pk_buf_q    <= '0;
      pk_cnt_q    <= '0;
      pk_ptr_q    <= '0;
      pk_loop_q   <= '0;
      for (int i = 0; i < sfe_pkg::NUM_CHANNELS; i++) begin
        chan_val_q[i] <= '0;
        chan_lo_q[i]  <= sfe_pkg::RESET_LOW;
        chan_hi_q[i]  <= sfe_pkg::RESET_HIGH;
      end
    end else begin
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
      pk_buf_q    <= pk_buf_d;
      pk_cnt_q    <= pk_cnt_d;
      pk_ptr_q    <= pk_ptr_d;
      pk_loop_q   <= pk_loop_d;
      if (cfg_we_i) begin
        flags_q <= cfg_wdata_i;
      end
      if (cw.uop == sfe_pkg::UOP_SC_WR) begin
        chan_val_q[ch_q] <= scaled;
      end
      if (cw.uop == sfe_pkg::UOP_RNG_WR) begin
        chan_lo_q[ch_q] <= rmin_q;
        chan_hi_q[ch_q] <= rmax_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ch_q   <= channel_i;
      pos_q  <= position_i;
      rmin_q <= range_min_i;
      rmax_q <= range_max_i;
    end
    if (emit_fire) begin
      out_byte_q <= byte_d;
      out_last_q <= cw.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign last_byte_o  = out_last_q;

  `SFE_ASSERT(a_last_is_end, (out_valid_o && last_byte_o) |-> (frame_byte_o == sfe_pkg::SBUS_END))
  `SFE_ASSERT(a_pack_drained, (upc_q == sfe_pkg::UPC_FLAGS) |-> ((pk_cnt_q == 5'd0) && (pk_ptr_q == 4'd0)))
  `SFE_ASSERT(a_frame_starts, (in_fire && (op_i == sfe_pkg::OP_FRAME)) |=> (upc_q == sfe_pkg::UPC_HDR))
  `SFE_ASSERT_NEVER(a_loop_range, (upc_q == sfe_pkg::UPC_PACK) && (pk_loop_q > 5'(sfe_pkg::PACKED_BYTES - 1)))

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SBUS frame encoder with scaling: self-checking testbench
// Drives position, range, frame and dropped commands into the encoder and
// checks every frame byte and its last-byte flag. Checks come from typed
// expectations or from an in-bench model of the channel, range and flag
// state. A short directed table runs first. Random commands follow under
// four handshake pressure settings, and the flags register changes between
// phases.
// ---------------------------------------------------------------------------
module tb;

  typedef struct packed {
    sfe_pkg::op_e      op;
    logic [3:0]        ch;
    logic signed [7:0] pos;
    logic [10:0]       rmin;
    logic [10:0]       rmax;
    logic              typed;
    logic [7:0]        byte21;
    logic [7:0]        byte22;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  localparam int POS_LIM  = 100;
  localparam int POS_SPAN = 200;
  localparam int DIR_ROWS = 22;
  localparam int PHASE_CMDS = 44;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [1:0]        op_i        = 2'd0;
  logic [3:0]        channel_i   = 4'd0;
  logic signed [7:0] position_i  = 8'sd0;
  logic [10:0]       range_min_i = 11'd0;
  logic [10:0]       range_max_i = 11'd0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        frame_byte_o;
  logic              last_byte_o;
  logic              cfg_we_i    = 1'b0;
  logic [3:0]        cfg_wdata_i = 4'd0;

  logic [10:0] chan_val [sfe_pkg::NUM_CHANNELS];
  logic [10:0] chan_lo  [sfe_pkg::NUM_CHANNELS];
  logic [10:0] chan_hi  [sfe_pkg::NUM_CHANNELS];
  logic [3:0]  flag_reg;

  frame_byte_t pending_bytes [$];
  cmd_t        dir_rows [DIR_ROWS];
  logic [3:0]  flag_set [4];
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          errors        = 0;
  int          cmds_sent     = 0;
  int          frames_sent   = 0;
  int          bytes_seen    = 0;

  sbus_frame_encoder_with_scaling_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .channel_i    (channel_i),
    .position_i   (position_i),
    .range_min_i  (range_min_i),
    .range_max_i  (range_max_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("timeout with %0d frame bytes outstanding", pending_bytes.size());
    $display("sbus_frame_encoder_with_scaling_unit regression: fail");
    $finish;
  end

  function automatic logic [10:0] scaled_value(logic signed [7:0] pos, logic [10:0] lo,
                                               logic [10:0] hi);
    int p;
    int v;
    p = pos;
    if (p > POS_LIM) p = POS_LIM;
    if (p < -POS_LIM) p = -POS_LIM;
    v = (p + POS_LIM) * (int'(hi) - int'(lo)) / POS_SPAN + int'(lo);
    return v[10:0];
  endfunction

  function automatic logic [7:0] packed_byte(int b);
    logic [7:0] r;
    int g;
    for (int i = 0; i < 8; i++) begin
      g = b * 8 + i;
      r[i] = chan_val[(g / sfe_pkg::CH_W) % sfe_pkg::NUM_CHANNELS][g % sfe_pkg::CH_W];
    end
    return r;
  endfunction

  task automatic push_frame(input cmd_t c);
    frame_byte_t fb;
    for (int k = 0; k < sfe_pkg::FRAME_BYTES; k++) begin
      if (k == 0) fb.data = sfe_pkg::SBUS_HEADER;
      else if (k <= sfe_pkg::PACKED_BYTES) begin
        if (!c.typed) fb.data = packed_byte(k - 1);
        else if (k == 21) fb.data = c.byte21;
        else if (k == 22) fb.data = c.byte22;
        else fb.data = 8'h00;
      end else if (k == sfe_pkg::PACKED_BYTES + 1) fb.data = {4'h0, flag_reg};
      else fb.data = sfe_pkg::SBUS_END;
      fb.last = (k == sfe_pkg::FRAME_BYTES - 1);
      pending_bytes.push_back(fb);
    end
  endtask

  task automatic apply_cmd(input cmd_t c);
    cmds_sent++;
    case (c.op)
      sfe_pkg::OP_SET_POS:   chan_val[c.ch] = scaled_value(c.pos, chan_lo[c.ch], chan_hi[c.ch]);
      sfe_pkg::OP_SET_RANGE: begin
        chan_lo[c.ch] = c.rmin;
        chan_hi[c.ch] = c.rmax;
      end
      sfe_pkg::OP_FRAME: begin
        frames_sent++;
        push_frame(c);
      end
      default: ;
    endcase
  endtask

  // hold valid high across back-to-back transfers; lower it only for a gap
  task automatic issue(input cmd_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= c.op;
    channel_i   <= c.ch;
    position_i  <= c.pos;
    range_min_i <= c.rmin;
    range_max_i <= c.rmax;
    do @(posedge clk_i); while (!in_ready_o);
    apply_cmd(c);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_flags(input logic [3:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    flag_reg = v;
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    pick = $urandom_range(99);
    if (pick < 42) c.op = sfe_pkg::OP_SET_POS;
    else if (pick < 64) c.op = sfe_pkg::OP_SET_RANGE;
    else if (pick < 93) c.op = sfe_pkg::OP_FRAME;
    else c.op = sfe_pkg::OP_NONE;
    c.ch = 4'($urandom_range(15));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(7))
        0: c.pos = -8'sd128;
        1: c.pos = 8'sd127;
        2: c.pos = -8'sd100;
        3: c.pos = 8'sd100;
        4: c.pos = -8'sd101;
        5: c.pos = 8'sd101;
        6: c.pos = 8'sd0;
        default: c.pos = -8'sd1;
      endcase
    end else c.pos = 8'($urandom);
    if ($urandom_range(4) == 0) c.rmin = $urandom_range(1) ? 11'h7FF : 11'h000;
    else c.rmin = 11'($urandom);
    if ($urandom_range(4) == 0) c.rmax = $urandom_range(1) ? 11'h7FF : 11'h000;
    else c.rmax = 11'($urandom);
    c.typed  = 1'b0;
    c.byte21 = 8'h00;
    c.byte22 = 8'h00;
    return c;
  endfunction

  always @(posedge clk_i) begin : rx_check
    frame_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        if (errors < 10) $display("unexpected frame byte %02h last %0b", frame_byte_o,
                                  last_byte_o);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        bytes_seen++;
        if (want.data !== frame_byte_o || want.last !== last_byte_o) begin
          if (errors < 10)
            $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                     want.data, want.last, frame_byte_o, last_byte_o);
          errors++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    int done;
    cmd_t c;
    int idle_tab [4];
    int stall_tab [4];
    idle_tab  = '{0, 62, 0, 19};
    stall_tab = '{0, 0, 62, 19};
    flag_set  = '{4'hF, 4'($urandom_range(14, 1)), 4'h0, 4'hA};
    for (int i = 0; i < sfe_pkg::NUM_CHANNELS; i++) begin
      chan_val[i] = '0;
      chan_lo[i]  = sfe_pkg::RESET_LOW;
      chan_hi[i]  = sfe_pkg::RESET_HIGH;
    end
    flag_reg = 4'h0;
    dir_rows = '{
      '{sfe_pkg::OP_FRAME,     4'd0,  8'sd0,    11'd0,    11'd0,    1'b1, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_RANGE, 4'd15, 8'sd0,    11'd2047, 11'd0,    1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_POS,   4'd15, -8'sd128, 11'd0,    11'd0,    1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_FRAME,     4'd0,  8'sd0,    11'd0,    11'd0,    1'b1, 8'hE0, 8'hFF},
      '{sfe_pkg::OP_SET_POS,   4'd15, 8'sd127,  11'd0,    11'd0,    1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_FRAME,     4'd0,  8'sd0,    11'd0,    11'd0,    1'b1, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_POS,   4'd0,  8'sd0,    11'd0,    11'd0,    1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_POS,   4'd1,  -8'sd101, 11'd0,    11'd0,    1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_POS,   4'd2,  8'sd101,  11'd0,    11'd0,    1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_RANGE, 4'd3,  8'sd0,    11'd0,    11'd2047, 1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_POS,   4'd3,  8'sd1,    11'd0,    11'd0,    1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_RANGE, 4'd4,  8'sd0,    11'd1000, 11'd3,    1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_POS,   4'd4,  -8'sd1,   11'd0,    11'd0,    1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_NONE,      4'd15, -8'sd1,   11'd2047, 11'd2047, 1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_RANGE, 4'd5,  8'sd127,  11'd5,    11'd5,    1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_POS,   4'd5,  -8'sd100, 11'd2047, 11'd2047, 1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_POS,   4'd6,  8'sd100,  11'd0,    11'd0,    1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_RANGE, 4'd7,  8'sd0,    11'd2047, 11'd2047, 1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_POS,   4'd7,  8'sd50,   11'd1234, 11'd55,   1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_FRAME,     4'd9,  8'sd77,   11'd1234, 11'd55,   1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_SET_POS,   4'd0,  -8'sd100, 11'd0,    11'd0,    1'b0, 8'h00, 8'h00},
      '{sfe_pkg::OP_FRAME,     4'd0,  8'sd0,    11'd0,    11'd0,    1'b0, 8'h00, 8'h00}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) issue(dir_rows[r]);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_flags(flag_set[ph]);
      send_idle_pct = idle_tab[ph];
      stall_pct     = stall_tab[ph];
      done = 0;
      while (done < PHASE_CMDS) begin
        c = random_cmd();
        issue(c);
        if (c.op != sfe_pkg::OP_NONE) done++;
      end
    end

    stall_pct = 0;
    settle();
    repeat (30) @(posedge clk_i);

    $display("%0d commands sent, %0d frames, %0d frame bytes checked", cmds_sent,
             frames_sent, bytes_seen);
    $display("four pressure settings, flag values %h %h %h %h, %0d mismatches",
             flag_set[0], flag_set[1], flag_set[2], flag_set[3], errors);
    if (errors == 0) begin
      $display("sbus_frame_encoder_with_scaling_unit regression: pass");
    end else begin
      $display("sbus_frame_encoder_with_scaling_unit regression: fail");
    end
    $finish;
  end

endmodule
